@@ hw/rtl/lce_pkg.sv @@
// Package for the LED crossfade engine: sizes, mode codes and sequencer states.
`default_nettype none
package lce_pkg;
    localparam int MAX_LEDS = 32;
    localparam int IDX_W    = 5;
    localparam int CNT_W    = 6;

    typedef enum logic [1:0] {
        MODE_SET  = 2'd0,
        MODE_LOAD = 2'd1,
        MODE_TICK = 2'd2,
        MODE_OFF  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_DIV,
        ST_BLEND,
        ST_EMIT
    } t_state;
endpackage
`default_nettype wire

@@ hw/rtl/lce_blend_unit.sv @@
// Shared blend unit: one channel byte of source + trunc((target-source)*portion/255).
`default_nettype none
module lce_blend_unit (
    input  wire logic [7:0] i_src,
    input  wire logic [7:0] i_dst,
    input  wire logic [7:0] i_portion,
    output logic      [7:0] o_value
);
    logic        neg;
    logic [7:0]  mag;
    logic [15:0] prod;
    logic [15:0] sum;
    logic [7:0]  quot;

    always_comb begin
        neg  = i_dst < i_src;
        mag  = neg ? (i_src - i_dst) : (i_dst - i_src);
        prod = {8'd0, mag} * {8'd0, i_portion};
        // exact divide by 255 for every product of two bytes
        sum  = prod + {8'd0, prod[15:8]} + 16'd1;
        quot = sum[15:8];
        o_value = neg ? (i_src - quot) : (i_src + quot);
    end
endmodule
`default_nettype wire

@@ hw/rtl/led_crossfade_engine.sv @@
// Top level of the LED crossfade engine: LED stores, fade sequencer, divider, frame output.
`default_nettype none
// Usage
//   Input channel: drive a word on i_mode, i_led_index, i_chan0..3, i_fade_steps and
//   i_batch_end with start high; it is taken at a clock edge where busy is low.
//   Output channel: each result word sits on the o_out_* ports and o_frame_end for one
//   cycle with o_strobe high. The receiver cannot stall; take every strobed word.
//   Configuration: i_cfg_we with i_cfg_wdata writes the chain length; write only while idle.
// Sequencing (n = LEDs in the chain, at most 32)
//   Set or load without batch end: no result.
//   Set batch end or all off: n results, one result per cycle.
//   Fade step (tick, or load batch end with nonzero steps): accept, tick state, the
//   bit-serial portion divider, then the channel-serial blend unit, one result per LED.
//   The final step of a fade skips the divider and copies targets.
//   A tick with no fade running sends nothing.
// Reset: synchronous, active low; clears shown values, ends any fade, chain length = 32.
module led_crossfade_engine (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [5:0] i_cfg_wdata,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] i_mode,
    input  wire logic [4:0] i_led_index,
    input  wire logic [7:0] i_chan0,
    input  wire logic [7:0] i_chan1,
    input  wire logic [7:0] i_chan2,
    input  wire logic [7:0] i_chan3,
    input  wire logic [7:0] i_fade_steps,
    input  wire logic       i_batch_end,
    output logic            o_strobe,
    output logic [4:0]      o_out_index,
    output logic [7:0]      o_out_chan0,
    output logic [7:0]      o_out_chan1,
    output logic [7:0]      o_out_chan2,
    output logic [7:0]      o_out_chan3,
    output logic            o_frame_end
);
    import lce_pkg::*;

    t_state r_state, n_state;

    logic [31:0] r_shown [MAX_LEDS];
    logic [31:0] r_start [MAX_LEDS];
    logic [31:0] r_goal  [MAX_LEDS];

    logic [CNT_W-1:0] r_chain_len;
    logic [7:0]       r_len;
    logic [7:0]       r_done;
    logic             r_snap;
    logic [IDX_W-1:0] r_cnt;
    logic [1:0]       r_ch;
    logic [23:0]      r_acc;
    logic [7:0]       r_rem;
    logic [15:0]      r_quo;
    logic [3:0]       r_bit;

    logic             r_out_valid;
    logic [4:0]       r_out_index;
    logic [31:0]      r_out_val;
    logic             r_out_frame_end;

    logic [CNT_W-1:0] eff_n;
    logic             accept;
    logic             idx_ok;
    logic             last_led;
    logic [7:0]       done_inc;
    logic             fade_over;
    logic [31:0]      in_val;
    logic [IDX_W-1:0] rd_addr;
    logic [31:0]      shown_rd;
    logic [31:0]      start_rd;
    logic [31:0]      goal_rd;
    logic [7:0]       src_byte;
    logic [7:0]       dst_byte;
    logic [7:0]       blend_byte;
    logic [8:0]       trial;
    logic             trial_ge;
    logic             led_step;
    logic             emit;
    logic [31:0]      emit_val;
    t_mode            mode;

    assign mode     = t_mode'(i_mode);
    assign eff_n    = (r_chain_len > CNT_W'(MAX_LEDS)) ? CNT_W'(MAX_LEDS) : r_chain_len;
    assign accept   = start && (r_state == ST_IDLE);
    assign busy     = (r_state != ST_IDLE);
    assign idx_ok   = {1'b0, i_led_index} < eff_n;
    assign last_led = ({1'b0, r_cnt} == (eff_n - CNT_W'(1)));
    assign done_inc = r_done + 8'd1;
    assign fade_over = done_inc >= r_len;
    assign in_val   = {i_chan3, i_chan2, i_chan1, i_chan0};

    // one read address: the addressed LED while idle, the sweep counter otherwise
    assign rd_addr  = (r_state == ST_IDLE) ? i_led_index : r_cnt;
    assign shown_rd = r_shown[rd_addr];
    assign start_rd = r_start[r_cnt];
    assign goal_rd  = r_goal[r_cnt];

    // pick the channel byte for the blend unit
    always_comb begin
        unique case (r_ch)
            2'd0: begin
                src_byte = start_rd[7:0];
                dst_byte = goal_rd[7:0];
            end
            2'd1: begin
                src_byte = start_rd[15:8];
                dst_byte = goal_rd[15:8];
            end
            2'd2: begin
                src_byte = start_rd[23:16];
                dst_byte = goal_rd[23:16];
            end
            default: begin
                src_byte = start_rd[31:24];
                dst_byte = goal_rd[31:24];
            end
        endcase
    end

    lce_blend_unit u_blend (
        .i_src     (src_byte),
        .i_dst     (dst_byte),
        .i_portion (r_quo[7:0]),
        .o_value   (blend_byte)
    );

    // restoring divider step: remainder stays below the fade length
    assign trial    = {r_rem, r_quo[15]};
    assign trial_ge = trial >= {1'b0, r_len};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (mode)
                        MODE_SET:  n_state = (i_batch_end && eff_n != '0) ? ST_EMIT : ST_IDLE;
                        MODE_LOAD: n_state = i_batch_end ? ST_TICK : ST_IDLE;
                        MODE_TICK: n_state = ST_TICK;
                        default:   n_state = (eff_n != '0) ? ST_EMIT : ST_IDLE;
                    endcase
                end
            end
            ST_TICK: begin
                if (r_len == 8'd0 || (fade_over && eff_n == '0)) begin
                    n_state = ST_IDLE;
                end else if (fade_over) begin
                    n_state = ST_BLEND;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_bit == 4'd15) begin
                    n_state = (eff_n != '0) ? ST_BLEND : ST_IDLE;
                end
            end
            ST_BLEND: begin
                if (led_step && last_led) begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (last_led) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sweep outputs: when an LED word goes out and with which value
    always_comb begin
        led_step = 1'b0;
        emit     = 1'b0;
        emit_val = shown_rd;
        unique case (r_state)
            ST_BLEND: begin
                led_step = r_snap || (r_ch == 2'd3);
                emit     = led_step;
                emit_val = r_snap ? goal_rd : {blend_byte, r_acc};
            end
            ST_EMIT: begin
                emit = 1'b1;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_chain_len <= CNT_W'(32);
            r_len       <= 8'd0;
            r_done      <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= emit;
            if (i_cfg_we) begin
                r_chain_len <= i_cfg_wdata;
            end
            if (accept) begin
                unique case (mode)
                    MODE_SET: r_len <= 8'd0;
                    MODE_LOAD: begin
                        if (i_batch_end) begin
                            r_len  <= i_fade_steps;
                            r_done <= 8'd0;
                        end
                    end
                    MODE_TICK: r_len <= r_len;
                    default:   r_len <= 8'd0;
                endcase
            end
            if (r_state == ST_TICK && r_len != 8'd0) begin
                r_done <= done_inc;
                if (fade_over) begin
                    r_len <= 8'd0;
                end
            end
        end
    end

    // sequencer payload: counters, divider and channel accumulator
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cnt <= '0;
            r_ch  <= 2'd0;
        end
        if (r_state == ST_TICK) begin
            r_snap <= fade_over;
            r_quo  <= {done_inc, 8'd0} - {8'd0, done_inc};
            r_rem  <= 8'd0;
            r_bit  <= 4'd0;
        end
        if (r_state == ST_DIV) begin
            r_rem <= trial_ge ? 8'(trial - {1'b0, r_len}) : trial[7:0];
            r_quo <= {r_quo[14:0], trial_ge};
            r_bit <= r_bit + 4'd1;
        end
        if (r_state == ST_BLEND && !r_snap) begin
            r_ch <= r_ch + 2'd1;
            unique case (r_ch)
                2'd0:    r_acc[7:0]   <= blend_byte;
                2'd1:    r_acc[15:8]  <= blend_byte;
                2'd2:    r_acc[23:16] <= blend_byte;
                default: r_acc        <= r_acc;
            endcase
        end
        if (emit) begin
            r_cnt <= r_cnt + IDX_W'(1);
        end
    end

    // shown values: reset to zero, written by set, all off and the blend sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_LEDS; i++) begin
                r_shown[i] <= 32'd0;
            end
        end else begin
            if (accept && mode == MODE_SET && idx_ok) begin
                r_shown[i_led_index] <= in_val;
            end
            if (accept && mode == MODE_OFF) begin
                for (int i = 0; i < MAX_LEDS; i++) begin
                    if (CNT_W'(i) < eff_n) begin
                        r_shown[i] <= 32'd0;
                    end
                end
            end
            if (r_state == ST_BLEND && led_step) begin
                r_shown[r_cnt] <= emit_val;
            end
        end
    end

    // fade source and target: hold until the next load
    always_ff @(posedge i_clk) begin
        if (accept && mode == MODE_LOAD && idx_ok) begin
            r_start[i_led_index] <= shown_rd;
            r_goal[i_led_index]  <= in_val;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_index     <= r_cnt;
            r_out_val       <= emit_val;
            r_out_frame_end <= last_led;
        end
    end

    assign o_strobe    = r_out_valid;
    assign o_out_index = r_out_index;
    assign o_out_chan0 = r_out_val[7:0];
    assign o_out_chan1 = r_out_val[15:8];
    assign o_out_chan2 = r_out_val[23:16];
    assign o_out_chan3 = r_out_val[31:24];
    assign o_frame_end = r_out_frame_end;

    // the divider only runs for a live fade
    a_div_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> r_len != 8'd0)
        else $error("divider running with no fade");

    // the last word of a frame leaves the sequencer idle
    a_frame_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_frame_end |-> r_state == ST_IDLE)
        else $error("sequencer still busy after frame end");

    // a word that is not the last keeps the sequencer busy
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_frame_end |-> r_state != ST_IDLE)
        else $error("frame cut short");
endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the LED crossfade engine: directed and random words, frame scoreboard.
`default_nettype none

// Holds the engine's shadow state, predicts the frames of each accepted word and checks them.
class frame_board;
    typedef struct packed {
        logic [4:0] index;
        logic [7:0] c0, c1, c2, c3;
        logic       last;
    } t_led_word;

    t_led_word    frames_due[$];
    logic [31:0]  shown[32];
    logic [31:0]  src[32];
    logic [31:0]  goal[32];
    bit           loaded[32];
    int unsigned  count_reg;
    int unsigned  fade_len;
    int unsigned  fade_cnt;
    int           errors;
    int           checked;

    function new();
        count_reg = 32;
        fade_len  = 0;
        fade_cnt  = 0;
        errors    = 0;
        checked   = 0;
        for (int i = 0; i < 32; i++) begin
            shown[i]  = '0;
            src[i]    = '0;
            goal[i]   = '0;
            loaded[i] = 0;
        end
    endfunction

    function int unsigned leds();
        return (count_reg > 32) ? 32 : count_reg;
    endfunction

    // True when a fade step would only read LEDs whose source and goal were written.
    function bit fade_safe();
        for (int i = 0; i < leds(); i++)
            if (!loaded[i]) return 0;
        return 1;
    endfunction

    function void write_count(logic [5:0] v);
        count_reg = {26'd0, v};
    endfunction

    function void push_frame();
        t_led_word w;
        for (int i = 0; i < leds(); i++) begin
            w.index = i[4:0];
            {w.c3, w.c2, w.c1, w.c0} = shown[i];
            w.last  = (i == leds() - 1);
            frames_due.push_back(w);
        end
    endfunction

    function logic [31:0] mix(logic [31:0] s, logic [31:0] t, int portion);
        logic [31:0] r;
        int a, b, q;
        for (int k = 0; k < 4; k++) begin
            a = s[8*k +: 8];
            b = t[8*k +: 8];
            q = ((b - a) * portion) / 255;
            r[8*k +: 8] = 8'(a + q);
        end
        return r;
    endfunction

    function void step_fade();
        int portion;
        if (fade_len == 0) return;
        fade_cnt = (fade_cnt + 1) & 8'hFF;
        portion  = (fade_cnt * 255) / fade_len;
        if (fade_cnt >= fade_len) begin
            fade_len = 0;
            for (int i = 0; i < leds(); i++) shown[i] = goal[i];
        end else begin
            for (int i = 0; i < leds(); i++) shown[i] = mix(src[i], goal[i], portion & 8'hFF);
        end
        push_frame();
    endfunction

    function void note_word(lce_pkg::t_mode mode, logic [4:0] idx, logic [31:0] val,
                            logic [7:0] steps, logic last);
        bit hit;
        hit = idx < leds();
        case (mode)
            lce_pkg::MODE_SET: begin
                if (hit) shown[idx] = val;
                fade_len = 0;
                if (last) push_frame();
            end
            lce_pkg::MODE_LOAD: begin
                if (hit) begin
                    src[idx]    = shown[idx];
                    goal[idx]   = val;
                    loaded[idx] = 1;
                end
                if (last) begin
                    fade_len = {24'd0, steps};
                    fade_cnt = 0;
                    step_fade();
                end
            end
            lce_pkg::MODE_TICK: step_fade();
            default: begin
                for (int i = 0; i < leds(); i++) shown[i] = '0;
                fade_len = 0;
                push_frame();
            end
        endcase
    endfunction

    function void check_word(t_led_word got);
        t_led_word exp_w;
        if (frames_due.size() == 0) begin
            $error("unexpected LED word index=%0d", got.index);
            errors++;
            return;
        end
        exp_w = frames_due.pop_front();
        checked++;
        if (got.index !== exp_w.index) begin
            $error("out_index exp=%0d got=%0d", exp_w.index, got.index); errors++;
        end
        if (got.c0 !== exp_w.c0) begin
            $error("out_chan0 exp=%0h got=%0h", exp_w.c0, got.c0); errors++;
        end
        if (got.c1 !== exp_w.c1) begin
            $error("out_chan1 exp=%0h got=%0h", exp_w.c1, got.c1); errors++;
        end
        if (got.c2 !== exp_w.c2) begin
            $error("out_chan2 exp=%0h got=%0h", exp_w.c2, got.c2); errors++;
        end
        if (got.c3 !== exp_w.c3) begin
            $error("out_chan3 exp=%0h got=%0h", exp_w.c3, got.c3); errors++;
        end
        if (got.last !== exp_w.last) begin
            $error("frame_end exp=%0b got=%0b", exp_w.last, got.last); errors++;
        end
    endfunction
endclass

module tb_top;
    import lce_pkg::*;

    localparam int WATCH_LIMIT = 3000;
    localparam int DRAIN_WAIT  = 200;

    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       i_cfg_we = 0;
    logic [5:0] i_cfg_wdata = '0;
    logic       start = 0;
    logic       busy;
    logic [1:0] i_mode = '0;
    logic [4:0] i_led_index = '0;
    logic [7:0] i_chan0 = '0, i_chan1 = '0, i_chan2 = '0, i_chan3 = '0;
    logic [7:0] i_fade_steps = '0;
    logic       i_batch_end = 0;
    logic       o_strobe;
    logic [4:0] o_out_index;
    logic [7:0] o_out_chan0, o_out_chan1, o_out_chan2, o_out_chan3;
    logic       o_frame_end;

    frame_board board;
    int  words_sent = 0;
    int  watch_cnt  = 0;
    bit  no_gaps    = 0;

    led_crossfade_engine dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .start(start), .busy(busy),
        .i_mode(i_mode), .i_led_index(i_led_index),
        .i_chan0(i_chan0), .i_chan1(i_chan1), .i_chan2(i_chan2), .i_chan3(i_chan3),
        .i_fade_steps(i_fade_steps), .i_batch_end(i_batch_end),
        .o_strobe(o_strobe), .o_out_index(o_out_index),
        .o_out_chan0(o_out_chan0), .o_out_chan1(o_out_chan1),
        .o_out_chan2(o_out_chan2), .o_out_chan3(o_out_chan3),
        .o_frame_end(o_frame_end)
    );

    always #4 i_clk = ~i_clk;

    // Take every strobed word; the receiver has no way to stall the engine.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            board.check_word({o_out_index, o_out_chan0, o_out_chan1, o_out_chan2,
                              o_out_chan3, o_frame_end});
    end

    // Watchdog: count cycles that move nothing and give up past the limit.
    always @(posedge i_clk) begin
        if (!i_rst_n || o_strobe || i_cfg_we || (start && !busy)) begin
            watch_cnt <= 0;
        end else if (watch_cnt >= WATCH_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end else begin
            watch_cnt <= watch_cnt + 1;
        end
    end

    // Drive one word, with a random gap ahead of it, and hold it until the engine takes it.
    task automatic send_word(t_mode mode, logic [4:0] idx, logic [31:0] val,
                             logic [7:0] steps, logic last);
        int gap;
        gap = 0;
        if (!no_gaps && $urandom_range(99) < 29) gap = $urandom_range(1, 5);
        if (gap > 0) begin
            start <= 0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1;
        i_mode       <= mode;
        i_led_index  <= idx;
        {i_chan3, i_chan2, i_chan1, i_chan0} <= val;
        i_fade_steps <= steps;
        i_batch_end  <= last;
        do @(posedge i_clk); while (busy);
        board.note_word(mode, idx, val, steps, last);
        words_sent++;
    endtask

    // Keep a fade from ever reading an LED whose source and goal were never loaded.
    task automatic send_safe(t_mode mode, logic [4:0] idx, logic [31:0] val,
                             logic [7:0] steps, logic last);
        if (!board.fade_safe()) begin
            if (mode == MODE_LOAD && last) steps = 8'd0;
            if (mode == MODE_TICK && board.fade_len != 0) mode = MODE_SET;
        end
        send_word(mode, idx, val, steps, last);
    endtask

    // Drain all frames, let the engine settle, then write the chain length.
    task automatic set_count(logic [5:0] v);
        start <= 0;
        while (board.frames_due.size() != 0) @(posedge i_clk);
        repeat (160) @(posedge i_clk);
        i_cfg_we    <= 1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 0;
        board.write_count(v);
    endtask

    // Load every active LED with fresh goals, start a fade and tick through part or all of it.
    task automatic fade_run();
        int n, steps, ticks;
        n = board.leds();
        steps = ($urandom_range(19) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 6);
        ticks = (steps > 8) ? $urandom_range(1, 4) : $urandom_range(0, steps + 1);
        for (int i = 0; i < n; i++) begin
            send_word(MODE_LOAD, 5'(n - 1 - i), $urandom, 8'(steps), 1'b0);
        end
        send_word(MODE_LOAD, 5'($urandom_range(31)), $urandom, 8'(steps), 1'b1);
        for (int t = 0; t < ticks; t++)
            send_safe(MODE_TICK, 5'($urandom), $urandom, 8'($urandom), 1'b0);
    endtask

    task automatic random_phase(int words);
        int goal_cnt;
        goal_cnt = words_sent + words;
        while (words_sent < goal_cnt) begin
            no_gaps = (words_sent >= 130 && words_sent < 190);
            if ($urandom_range(99) < 70)
                fade_run();
            else
                send_safe(t_mode'($urandom_range(3)), 5'($urandom), $urandom, 8'($urandom),
                          1'($urandom_range(1)));
        end
    endtask

    initial begin
        board = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: four LEDs, extremes, out-of-range index, full fade, idle tick, zero steps.
        set_count(6'd4);
        send_word(MODE_SET, 5'd0, 32'hFFFF_FFFF, 8'd0, 1'b0);
        send_word(MODE_SET, 5'd31, 32'h00FF_00FF, 8'd0, 1'b1);
        send_word(MODE_SET, 5'd3, 32'h8001_7F80, 8'd0, 1'b1);
        for (int i = 0; i < 4; i++)
            send_word(MODE_LOAD, i[4:0], (i[0] ? 32'h0000_0000 : 32'hFFFF_FFFF), 8'd3, i == 3);
        send_word(MODE_TICK, 5'd0, 32'h0, 8'd0, 1'b0);
        send_word(MODE_TICK, 5'd0, 32'h0, 8'd0, 1'b0);
        send_word(MODE_TICK, 5'd0, 32'h0, 8'd0, 1'b0);
        send_word(MODE_LOAD, 5'd1, 32'h1234_5678, 8'd0, 1'b1);
        send_word(MODE_LOAD, 5'd2, 32'hA5A5_5A5A, 8'd255, 1'b1);
        send_word(MODE_TICK, 5'd0, 32'h0, 8'd0, 1'b0);
        send_word(MODE_LOAD, 5'd20, 32'hFFFF_FFFF, 8'd1, 1'b1);
        send_word(MODE_SET, 5'd17, 32'hDEAD_BEEF, 8'd0, 1'b1);
        send_word(MODE_TICK, 5'd0, 32'h0, 8'd0, 1'b0);
        send_word(MODE_OFF, 5'd31, 32'hFFFF_FFFF, 8'd255, 1'b1);

        // Random phases over several chain lengths, including empty and oversized.
        set_count(6'd32);
        random_phase(95);
        set_count(6'd1);
        random_phase(35);
        set_count(6'd0);
        random_phase(20);
        set_count(6'd63);
        random_phase(55);
        set_count(6'($urandom_range(2, 31)));
        random_phase(65);
        start <= 0;

        while (board.frames_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (board.frames_due.size() != 0) begin
            $error("%0d LED words never arrived", board.frames_due.size());
            board.errors++;
        end
        $display("Sent %0d words over six chain lengths (0, 1, 4, 32, 63, random);",
                 words_sent);
        $display("checked %0d LED words, %0d mismatches.", board.checked, board.errors);
        if (board.errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule
`default_nettype wire

@@ sim.f @@
hw/rtl/lce_pkg.sv
hw/rtl/lce_blend_unit.sv
hw/rtl/led_crossfade_engine.sv
tb/tb_top.sv
